/* rtl/bis_pkg.sv */
// Shared types and constants for the bilinear image scaler.
package bis_pkg;

  // Field and register widths.
  localparam int SRC_DIM_W  = 10;
  localparam int CHAN_W     = 3;
  localparam int STEP_W     = 24;
  localparam int COORD_W    = 12;
  localparam int SAMPLE_W   = 8;
  localparam int CIDX_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Fixed-point layout: Q8.16 step, 16-bit fractions.
  localparam int FRAC_W  = 16;
  localparam int IPART_W = COORD_W + STEP_W - FRAC_W;

  // Shared multiply-accumulate unit widths.
  localparam int MAC_A_W = 24;
  localparam int MAC_B_W = FRAC_W + 1;
  localparam int ACC_W   = MAC_A_W + MAC_B_W;

  // One in Q.16, the full weight of a neighbor.
  localparam logic [MAC_B_W-1:0] Q_ONE = MAC_B_W'(1) << FRAC_W;

  // Default sizes of the frame store.
  localparam int MAX_WIDTH_DEF    = 512;
  localparam int MAX_HEIGHT_DEF   = 512;
  localparam int MAX_CHANNELS_DEF = 4;

  // Register reset values.
  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = SRC_DIM_W'(1);
  localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = SRC_DIM_W'(1);
  localparam logic [CHAN_W-1:0]    CHAN_CNT_RST   = CHAN_W'(3);
  localparam logic [STEP_W-1:0]    INV_STEP_RST   = STEP_W'(65536);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP  = 2'd3;

  // Input operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;   // update the accumulator this cycle
    logic clr;  // load the product instead of adding it
  } bis_mac_ctl_t;

endpackage

/* rtl/bis_mac.sv */
// Shared multiply-accumulate unit used for every product of the scaler.
module bis_mac (
  input  logic                          clk,
  input  bis_pkg::bis_mac_ctl_t         ctl,
  input  logic [bis_pkg::MAC_A_W-1:0]   op_a,
  input  logic [bis_pkg::MAC_B_W-1:0]   op_b,
  output logic [bis_pkg::ACC_W-1:0]     acc
);
  import bis_pkg::*;

  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] acc_r;

  // Full-width product of the two operands.
  assign prod = ACC_W'(op_a) * ACC_W'(op_b);

  // Accumulator: load or add the product when enabled.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= ctl.clr ? prod : acc_r + prod;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/bilinear_image_scaler_top.sv */
// Top level of the bilinear image scaler: frame store, sequencer and result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_op, in_sample, in_out_x, in_out_y
//   out      output     out_valid/out_stall  out_value, out_channel_index, out_last
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// Loads can arrive in every cycle while the input is not stalled.
// A request runs through the mapping and address setup, then the read and blend
// steps for each channel, and each result waits in the output register until taken.
// All products run one after another through the single shared multiplier.
// After reset and after each register write the input is stalled while the
// clamped sizes and the store total are recomputed.
// A stall on the output holds the sequencer; the frame store is not cleared.
module bilinear_image_scaler_top #(
  parameter int MAX_WIDTH    = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = bis_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = bis_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [bis_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [bis_pkg::COORD_W-1:0]      in_out_x,
  input  logic [bis_pkg::COORD_W-1:0]      in_out_y,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bis_pkg::SAMPLE_W-1:0]     out_value,
  output logic [bis_pkg::CIDX_W-1:0]       out_channel_index,
  output logic                             out_last,
  // Configuration port
  input  logic                             cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bis_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW     = $clog2(DEPTH);
  localparam int WH_W   = 2 * SRC_DIM_W;
  localparam int TOT_W  = WH_W + CHAN_W;
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(3);

  // Steps of the per-channel sequence.
  localparam logic [2:0] STP_RD1  = 3'd0;  // read first neighbor
  localparam logic [2:0] STP_TOP0 = 3'd1;  // left weight, upper row
  localparam logic [2:0] STP_TOP1 = 3'd2;  // right weight, upper row
  localparam logic [2:0] STP_BOT0 = 3'd3;  // left weight, lower row
  localparam logic [2:0] STP_BOT1 = 3'd4;  // right weight, lower row
  localparam logic [2:0] STP_VER0 = 3'd5;  // upper row vertical weight
  localparam logic [2:0] STP_VER1 = 3'd6;  // lower row vertical weight
  localparam logic [2:0] STP_DONE = 3'd7;  // result ready in accumulator

  typedef enum logic [3:0] {
    ST_IDLE, ST_PX, ST_PY, ST_CAP, ST_ROW, ST_BASE, ST_ADDR, ST_CHAN, ST_OUT
  } state_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] pos;   // clamped neighbor position
    logic                 nxt;   // the far neighbor lies one further on
  } pos_t;

  // Clamp an integer source position to the image and check the far neighbor.
  function automatic pos_t map_pos(input logic [IPART_W-1:0] ipart,
                                   input logic [SRC_DIM_W-1:0] dim);
    logic [SRC_DIM_W-1:0] last;
    pos_t                 res;
    last    = dim - SRC_DIM_W'(1);
    res.pos = (ipart > IPART_W'(last)) ? last : ipart[SRC_DIM_W-1:0];
    res.nxt = ((SRC_DIM_W+1)'(res.pos) + (SRC_DIM_W+1)'(1)) < (SRC_DIM_W+1)'(dim);
    return res;
  endfunction

  // Configuration registers.
  logic [SRC_DIM_W-1:0] src_width_r;
  logic [SRC_DIM_W-1:0] src_height_r;
  logic [CHAN_W-1:0]    chan_cnt_r;
  logic [STEP_W-1:0]    inv_step_r;
  logic [SETTLE_W-1:0]  settle_r;

  // Clamped sizes and store total, rebuilt after every register write.
  logic [SRC_DIM_W-1:0] w_clamp, h_clamp;
  logic [CHAN_W-1:0]    n_clamp;
  logic [SRC_DIM_W-1:0] w_eff_r, h_eff_r;
  logic [CHAN_W-1:0]    n_eff_r;
  logic [WH_W-1:0]      wh_r;
  logic [TOT_W-1:0]     total_r;

  // Sequencer state.
  state_t               state_r;
  logic [2:0]           step_r;
  logic [CIDX_W-1:0]    chan_r;
  logic [AW-1:0]        load_addr_r;
  logic [AW-1:0]        load_addr_nxt;
  logic [31:0]          load_inc;
  logic                 load_fire;
  logic                 req_fire;

  // Request payload and derived geometry.
  logic [COORD_W-1:0]   req_x_r, req_y_r;
  logic [FRAC_W-1:0]    fx_r, fy_r;
  logic [SRC_DIM_W-1:0] x1_r, y1_r;
  logic                 dx_r, dy_r;
  logic [AW-1:0]        stride_r;
  logic [AW-1:0]        addr1_r, addr2_r, addr3_r, addr4_r;
  logic [AW-1:0]        addr_base, addr_dx, addr_dy;
  logic [MAC_A_W-1:0]   top_r, bot_r;
  pos_t                 x_map, y_map;

  // Frame store.
  logic [SAMPLE_W-1:0]  store_mem [DEPTH];
  logic [AW-1:0]        rd_addr;
  logic [SAMPLE_W-1:0]  rd_data_r;

  // Shared arithmetic unit.
  bis_mac_ctl_t         mac_ctl;
  logic [MAC_A_W-1:0]   mac_a;
  logic [MAC_B_W-1:0]   mac_b;
  logic [ACC_W-1:0]     acc;

  // Output register.
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_value_r;
  logic [CIDX_W-1:0]    out_chan_r;
  logic                 out_last_r;

  // Register writes; each one restarts the settle count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      chan_cnt_r   <= CHAN_CNT_RST;
      inv_step_r   <= INV_STEP_RST;
      settle_r     <= SETTLE_CYC;
    end else if (cfg_we) begin
      settle_r <= SETTLE_CYC;
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  src_width_r  <= cfg_data[SRC_DIM_W-1:0];
        CFG_SOURCE_HEIGHT: src_height_r <= cfg_data[SRC_DIM_W-1:0];
        CFG_CHANNEL_COUNT: chan_cnt_r   <= cfg_data[CHAN_W-1:0];
        CFG_INVERSE_STEP:  inv_step_r   <= cfg_data[STEP_W-1:0];
      endcase
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_W'(1);
    end
  end

  // Out-of-range sizes act as the nearest legal value.
  always_comb begin
    if (src_width_r == '0) begin
      w_clamp = SRC_DIM_W'(1);
    end else if (32'(src_width_r) > MAX_WIDTH) begin
      w_clamp = SRC_DIM_W'(MAX_WIDTH);
    end else begin
      w_clamp = src_width_r;
    end
    if (src_height_r == '0) begin
      h_clamp = SRC_DIM_W'(1);
    end else if (32'(src_height_r) > MAX_HEIGHT) begin
      h_clamp = SRC_DIM_W'(MAX_HEIGHT);
    end else begin
      h_clamp = src_height_r;
    end
    if (chan_cnt_r == '0) begin
      n_clamp = CHAN_W'(1);
    end else if (32'(chan_cnt_r) > MAX_CHANNELS) begin
      n_clamp = CHAN_W'(MAX_CHANNELS);
    end else begin
      n_clamp = chan_cnt_r;
    end
  end

  // Size pipeline: clamp, then width times height, then times channels.
  always_ff @(posedge clk) begin
    w_eff_r <= w_clamp;
    h_eff_r <= h_clamp;
    n_eff_r <= n_clamp;
    wh_r    <= WH_W'(w_eff_r) * WH_W'(h_eff_r);
    total_r <= TOT_W'(wh_r) * TOT_W'(n_eff_r);
  end

  // Handshake and transaction strobes.
  assign in_stall  = (state_r != ST_IDLE) || (settle_r != '0);
  assign load_fire = in_valid && !in_stall && (in_op == OP_LOAD);
  assign req_fire  = in_valid && !in_stall && (in_op == OP_REQUEST);

  // Load pointer wraps at the image total, or at once when already past it.
  always_comb begin
    load_inc = 32'(load_addr_r) + 32'd1;
    if ((32'(load_addr_r) >= 32'(total_r)) || (load_inc >= 32'(total_r))) begin
      load_addr_nxt = '0;
    end else begin
      load_addr_nxt = load_inc[AW-1:0];
    end
  end

  // Frame store write port.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      store_mem[load_addr_r] <= in_sample;
    end
  end

  // Frame store read port: one neighbor per cycle.
  always_comb begin
    unique case (step_r)
      STP_RD1:  rd_addr = addr1_r + AW'(chan_r);
      STP_TOP0: rd_addr = addr2_r + AW'(chan_r);
      STP_TOP1: rd_addr = addr3_r + AW'(chan_r);
      default:  rd_addr = addr4_r + AW'(chan_r);
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[rd_addr];
  end

  // Neighbor positions from the integer part of the mapped coordinate.
  assign x_map = map_pos(acc[FRAC_W +: IPART_W], w_eff_r);
  assign y_map = map_pos(acc[FRAC_W +: IPART_W], h_eff_r);

  // Corner addresses from the upper-left one.
  assign addr_base = acc[AW-1:0];
  assign addr_dx   = dx_r ? AW'(n_eff_r) : '0;
  assign addr_dy   = dy_r ? stride_r : '0;

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctl = '{en: 1'b0, clr: 1'b1};
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      ST_PX: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(inv_step_r);
        mac_b      = MAC_B_W'(req_x_r);
      end
      ST_PY: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(inv_step_r);
        mac_b      = MAC_B_W'(req_y_r);
      end
      ST_CAP: begin
        // Row stride in bytes.
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(w_eff_r);
        mac_b      = MAC_B_W'(n_eff_r);
      end
      ST_ROW: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(y1_r);
        mac_b      = MAC_B_W'(w_eff_r);
      end
      ST_BASE: begin
        // Pixel index of the upper-left neighbor times channels.
        mac_ctl.en = 1'b1;
        mac_a      = acc[MAC_A_W-1:0] + MAC_A_W'(x1_r);
        mac_b      = MAC_B_W'(n_eff_r);
      end
      ST_CHAN: begin
        unique case (step_r)
          STP_TOP0, STP_BOT0: begin
            mac_ctl.en = 1'b1;
            mac_a      = MAC_A_W'(rd_data_r);
            mac_b      = Q_ONE - MAC_B_W'(fx_r);
          end
          STP_TOP1, STP_BOT1: begin
            mac_ctl    = '{en: 1'b1, clr: 1'b0};
            mac_a      = MAC_A_W'(rd_data_r);
            mac_b      = MAC_B_W'(fx_r);
          end
          STP_VER0: begin
            mac_ctl.en = 1'b1;
            mac_a      = top_r;
            mac_b      = Q_ONE - MAC_B_W'(fy_r);
          end
          STP_VER1: begin
            mac_ctl    = '{en: 1'b1, clr: 1'b0};
            mac_a      = bot_r;
            mac_b      = MAC_B_W'(fy_r);
          end
          default: begin
            mac_ctl.en = 1'b0;
          end
        endcase
      end
      default: begin
        mac_ctl.en = 1'b0;
      end
    endcase
  end

  bis_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // Sequencer, load pointer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STP_RD1;
      chan_r      <= '0;
      load_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (load_fire) begin
            load_addr_r <= load_addr_nxt;
          end
          if (req_fire) begin
            req_x_r <= in_out_x;
            req_y_r <= in_out_y;
            state_r <= ST_PX;
          end
        end
        ST_PX: begin
          state_r <= ST_PY;
        end
        ST_PY: begin
          // Accumulator holds the mapped column.
          x1_r    <= x_map.pos;
          dx_r    <= x_map.nxt;
          fx_r    <= acc[FRAC_W-1:0];
          state_r <= ST_CAP;
        end
        ST_CAP: begin
          // Accumulator holds the mapped row.
          y1_r    <= y_map.pos;
          dy_r    <= y_map.nxt;
          fy_r    <= acc[FRAC_W-1:0];
          state_r <= ST_ROW;
        end
        ST_ROW: begin
          stride_r <= acc[AW-1:0];
          state_r  <= ST_BASE;
        end
        ST_BASE: begin
          state_r <= ST_ADDR;
        end
        ST_ADDR: begin
          addr1_r <= addr_base;
          addr2_r <= addr_base + addr_dx;
          addr3_r <= addr_base + addr_dy;
          addr4_r <= addr_base + addr_dy + addr_dx;
          chan_r  <= '0;
          step_r  <= STP_RD1;
          state_r <= ST_CHAN;
        end
        ST_CHAN: begin
          step_r <= step_r + 3'd1;
          if (step_r == STP_BOT0) begin
            top_r <= acc[MAC_A_W-1:0];
          end
          if (step_r == STP_VER0) begin
            bot_r <= acc[MAC_A_W-1:0];
          end
          if (step_r == STP_DONE) begin
            out_value_r <= acc[2*FRAC_W +: SAMPLE_W];
            out_chan_r  <= chan_r;
            out_last_r  <= ((CHAN_W'(chan_r) + CHAN_W'(1)) == n_eff_r);
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            step_r      <= STP_RD1;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              chan_r  <= chan_r + CIDX_W'(1);
              state_r <= ST_CHAN;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_channel_index = out_chan_r;
  assign out_last          = out_last_r;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the bilinear image scaler top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int unsigned RAND_REQUESTS    = 140;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned IDLE_GAP         = 60;
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam int unsigned MAX_RANDOM_BYTES = 32;
  localparam int unsigned STORE_BYTES      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * MAX_CHANNELS_DEF;

  // Receiver stall patterns.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

  // One channel result as the block presents it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [CIDX_W-1:0]   channel;
    logic                last;
  } channel_result_t;

  // Scoreboard: mirrors the frame store and registers, predicts channel results.
  class pixel_scoreboard;
    logic [SAMPLE_W-1:0] frame_bytes [int unsigned];
    int unsigned         load_ptr;
    logic [SRC_DIM_W-1:0] width_reg;
    logic [SRC_DIM_W-1:0] height_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [STEP_W-1:0]    step_reg;
    channel_result_t     expected_channels [$];
    int unsigned         mismatches;
    int unsigned         results_checked;

    function new();
      frame_bytes.delete();
      expected_channels.delete();
      load_ptr = 0;
      width_reg = SRC_WIDTH_RST;
      height_reg = SRC_HEIGHT_RST;
      chan_reg = CHAN_CNT_RST;
      step_reg = INV_STEP_RST;
      mismatches = 0;
      results_checked = 0;
    endfunction

    static function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_size(width_reg, MAX_WIDTH_DEF);
    endfunction

    function int unsigned eff_height();
      return clamp_size(height_reg, MAX_HEIGHT_DEF);
    endfunction

    function int unsigned eff_chans();
      return clamp_size(chan_reg, MAX_CHANNELS_DEF);
    endfunction

    function int unsigned image_bytes();
      return eff_width() * eff_height() * eff_chans();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SOURCE_WIDTH:  width_reg = data[SRC_DIM_W-1:0];
        CFG_SOURCE_HEIGHT: height_reg = data[SRC_DIM_W-1:0];
        CFG_CHANNEL_COUNT: chan_reg = data[CHAN_W-1:0];
        CFG_INVERSE_STEP:  step_reg = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Write pointer wraps at the image size, also when it already lies past it.
    function void store_sample(logic [SAMPLE_W-1:0] sample);
      int unsigned total;
      int unsigned next_ptr;
      total = image_bytes();
      if (load_ptr < STORE_BYTES) frame_bytes[load_ptr] = sample;
      next_ptr = load_ptr + 1;
      if (load_ptr >= total || next_ptr >= total) next_ptr = 0;
      load_ptr = next_ptr;
    endfunction

    task read_byte(input int unsigned addr, output logic [SAMPLE_W-1:0] b);
      if (frame_bytes.exists(addr)) begin
        b = frame_bytes[addr];
      end else begin
        b = '0;
        report($sformatf("request reads unwritten store entry %0d", addr));
      end
    endtask

    // Map the output pixel back onto the source and blend four neighbors per channel.
    task interpolate_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      logic [COORD_W+STEP_W-1:0] pos_x;
      logic [COORD_W+STEP_W-1:0] pos_y;
      logic [IPART_W-1:0]        int_x;
      logic [IPART_W-1:0]        int_y;
      logic [MAC_B_W-1:0]        wx0, wx1, wy0, wy1;
      logic [SAMPLE_W-1:0]       p00, p01, p10, p11;
      logic [24:0]               top_row;
      logic [24:0]               bottom_row;
      logic [47:0]               acc;
      int unsigned               w, h, n, x1, y1, x2, y2, c;
      channel_result_t           res;
      w = eff_width();
      h = eff_height();
      n = eff_chans();
      pos_x = (COORD_W+STEP_W)'(x) * (COORD_W+STEP_W)'(step_reg);
      pos_y = (COORD_W+STEP_W)'(y) * (COORD_W+STEP_W)'(step_reg);
      int_x = pos_x[COORD_W+STEP_W-1:FRAC_W];
      int_y = pos_y[COORD_W+STEP_W-1:FRAC_W];
      wx1 = {1'b0, pos_x[FRAC_W-1:0]};
      wy1 = {1'b0, pos_y[FRAC_W-1:0]};
      wx0 = Q_ONE - wx1;
      wy0 = Q_ONE - wy1;
      // Positions past the image saturate; right and lower neighbors clamp.
      x1 = (int_x > w - 1) ? w - 1 : int_x;
      y1 = (int_y > h - 1) ? h - 1 : int_y;
      x2 = (x1 + 1 >= w) ? w - 1 : x1 + 1;
      y2 = (y1 + 1 >= h) ? h - 1 : y1 + 1;
      for (c = 0; c < n; c++) begin
        read_byte((y1 * w + x1) * n + c, p00);
        read_byte((y1 * w + x2) * n + c, p01);
        read_byte((y2 * w + x1) * n + c, p10);
        read_byte((y2 * w + x2) * n + c, p11);
        top_row = 25'(p00) * 25'(wx0) + 25'(p01) * 25'(wx1);
        bottom_row = 25'(p10) * 25'(wx0) + 25'(p11) * 25'(wx1);
        acc = 48'(top_row) * 48'(wy0) + 48'(bottom_row) * 48'(wy1);
        res.value = (acc[47:32] > 16'd255) ? 8'hFF : acc[39:32];
        res.channel = CIDX_W'(c);
        res.last = (c + 1 == n);
        expected_channels.push_back(res);
      end
    endtask

    task note_input(input logic op, input logic [SAMPLE_W-1:0] sample,
                    input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      if (op == OP_LOAD) store_sample(sample);
      else interpolate_pixel(x, y);
    endtask

    task check_result(input logic [SAMPLE_W-1:0] value, input logic [CIDX_W-1:0] channel,
                      input logic last);
      channel_result_t exp_res;
      results_checked++;
      if (expected_channels.size() == 0) begin
        report($sformatf("unexpected result value=%0d channel=%0d last=%0b",
                         value, channel, last));
      end else begin
        exp_res = expected_channels.pop_front();
        if (value !== exp_res.value || channel !== exp_res.channel ||
            last !== exp_res.last) begin
          report($sformatf("got value=%0d channel=%0d last=%0b, want %0d/%0d/%0b",
                           value, channel, last,
                           exp_res.value, exp_res.channel, exp_res.last));
        end
      end
    endtask

    task check_leftover();
      if (expected_channels.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_channels.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [COORD_W-1:0]    in_out_x;
  logic [COORD_W-1:0]    in_out_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [SAMPLE_W-1:0]   out_value;
  logic [CIDX_W-1:0]     out_channel_index;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard scaler_sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned loads_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned phases = 0;
  int unsigned holdoffs = 0;
  logic        hold_off_req = 1'b0;

  bilinear_image_scaler_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_sample         (in_sample),
    .in_out_x          (in_out_x),
    .in_out_y          (in_out_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_channel_index (out_channel_index),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, scaler_sb.expected_channels.size());
      $display("** bilinear_image_scaler_top: FAILED **");
      $finish;
    end
  end

  // Result monitor: every accepted transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      scaler_sb.check_result(out_value, out_channel_index, out_last);
  end

  // Receiver: stall patterns of its own, plus a long hold-off on request.
  initial begin
    rx_mode_t    mode;
    int unsigned left;
    out_stall = 1'b0;
    mode = RX_FREE;
    left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holdoffs++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(4, 64);
        end
        left--;
        case (mode)
          RX_FREE:      out_stall = 1'b0;
          RX_LIGHT:     out_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY:     out_stall = ($urandom_range(0, 3) != 0);
          RX_ALTERNATE: out_stall = ~out_stall;
          default:      out_stall = 1'b0;
        endcase
      end
    end
  end

  // Offer one input transaction in bursts with random gaps; entered and left at a falling edge.
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] sample,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_op = op;
    in_sample = sample;
    in_out_x = x;
    in_out_y = y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scaler_sb.note_input(op, sample, x, y);
    if (op == OP_LOAD) loads_sent++;
    else requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_load();
    send_item(OP_LOAD, rand_sample(), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_request(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(OP_REQUEST, SAMPLE_W'($urandom), x, y);
  endtask

  // One byte more than the image covers every entry wherever the pointer starts.
  task automatic load_image();
    repeat (scaler_sb.image_bytes() + 1) send_load();
  endtask

  // Coordinates mostly within reach of the image, some at the field extremes.
  function automatic logic [COORD_W-1:0] rand_coord(int unsigned dim);
    longint unsigned reach;
    reach = (longint'(dim) + 1) << FRAC_W;
    reach = reach / ((scaler_sb.step_reg == 0) ? 1 : scaler_sb.step_reg);
    if (reach > 4095) reach = 4095;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, reach));
    endcase
  endfunction

  function automatic logic [SRC_DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return SRC_DIM_W'(512);
      3:       return SRC_DIM_W'($urandom_range(0, 1023));
      default: return SRC_DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STEP_W'(65536);
      2:       return '1;
      3:       return STEP_W'($urandom);
      4:       return STEP_W'($urandom_range(1, 16384));
      default: return STEP_W'($urandom_range(16384, 131072));
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    scaler_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Write all four registers; unused upper data bits carry random junk.
  task automatic set_image(input logic [SRC_DIM_W-1:0] w, input logic [SRC_DIM_W-1:0] h,
                           input logic [CHAN_W-1:0] n, input logic [STEP_W-1:0] step);
    cfg_write(CFG_SOURCE_WIDTH, {(CFG_DATA_W-SRC_DIM_W)'($urandom), w});
    cfg_write(CFG_SOURCE_HEIGHT, {(CFG_DATA_W-SRC_DIM_W)'($urandom), h});
    cfg_write(CFG_CHANNEL_COUNT, {(CFG_DATA_W-CHAN_W)'($urandom), n});
    cfg_write(CFG_INVERSE_STEP, step);
    phases++;
  endtask

  // Wait for every predicted result, then let the block settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (scaler_sb.expected_channels.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    logic [SRC_DIM_W-1:0] w, h;
    logic [CHAN_W-1:0]    n;
    int unsigned          rand_requests;
    int unsigned          batch;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_sample = '0;
    in_out_x = '0;
    in_out_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SOURCE_WIDTH;
    cfg_data = '0;
    rand_requests = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset register values.
    load_image();
    send_request('0, '0);
    send_request('1, '1);

    // Upscale by two with four channels, while the output is held off.
    wait_idle();
    set_image(4, 3, 4, 32768);
    load_image();
    hold_off_req = 1'b1;
    send_request(0, 0);
    send_request(1, 1);
    send_request(7, 5);
    send_request(3, 2);
    send_request(5, 0);
    send_request('1, '1);

    // Zero step maps everything onto the first pixel.
    wait_idle();
    cfg_write(CFG_INVERSE_STEP, '0);
    send_request(100, 200);
    send_request('1, '1);

    // Width and channels of zero, a short column, full-scale step.
    wait_idle();
    set_image('0, 5, '0, '1);
    load_image();
    send_request(0, 0);
    send_request(0, 1);
    send_request(0, 300);
    send_request('1, '1);

    // Zero height, channel count above the maximum, smallest step, wrapping loads.
    wait_idle();
    set_image(3, '0, '1, 1);
    load_image();
    repeat (30) send_load();
    send_request('1, '1);
    send_request(0, 0);
    send_request(2048, 17);

    // Shrink the image so the load pointer lies past its end.
    wait_idle();
    set_image(2, 2, 1, 40000);
    load_image();
    send_request(1, 1);
    send_request(2, 3);
    send_request(0, 1);

    // Random phases: new registers, a full image load, then requests with stray loads.
    while (rand_requests < RAND_REQUESTS) begin
      wait_idle();
      w = rand_dim();
      h = rand_dim();
      n = CHAN_W'($urandom_range(0, 7));
      while (pixel_scoreboard::clamp_size(w, MAX_WIDTH_DEF) *
             pixel_scoreboard::clamp_size(h, MAX_HEIGHT_DEF) *
             pixel_scoreboard::clamp_size(n, MAX_CHANNELS_DEF) > MAX_RANDOM_BYTES) begin
        w = SRC_DIM_W'($urandom_range(0, 8));
        h = SRC_DIM_W'($urandom_range(0, 2));
      end
      set_image(w, h, n, rand_step());
      load_image();
      if (phases == 6) hold_off_req = 1'b1;
      batch = $urandom_range(4, 40);
      repeat (batch) begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_load();
        send_request(rand_coord(scaler_sb.eff_width()), rand_coord(scaler_sb.eff_height()));
        rand_requests++;
      end
    end

    wait_idle();
    scaler_sb.check_leftover();
    $display("Ran %0d register settings with %0d load and %0d request transactions;",
             phases, loads_sent, requests_sent);
    $display("%0d channel results checked, %0d long output hold-offs, %0d mismatches.",
             scaler_sb.results_checked, holdoffs, scaler_sb.mismatches);
    if (scaler_sb.mismatches == 0) begin
      $display("** bilinear_image_scaler_top: PASSED **");
    end else begin
      $display("** bilinear_image_scaler_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bis_pkg.sv
rtl/bis_mac.sv
rtl/bilinear_image_scaler_top.sv
sim/tb.sv
